@@ sv/grt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grt_pkg
// shared types and constants of the greedy geographic route tracer
// ----------------------------------------------------------------------------
package grt_pkg;

    localparam int COORD_W  = 16;
    localparam int IDX_W    = 10;
    localparam int CFG_W    = 16;
    localparam int CNT_OUT_W = 11;

    // input opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_TRACE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_REACHED = 2'd0;
    localparam logic [1:0] ST_LOOP    = 2'd1;
    localparam logic [1:0] ST_NO_HOP  = 2'd2;
    localparam logic [1:0] ST_IS_DEST = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [1:0] CFG_DEST_ID    = 2'd1;
    localparam logic [1:0] CFG_COMM_RANGE = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic       load_wr;
        logic       start_q;
        logic       clr_step;
        logic       rd_me;
        logic       latch_me;
        logic       scan_step;
        logic       vis_rd;
        logic       vis_mark;
        logic       adv_hop;
        logic       set_res;
        logic [1:0] res_status;
        logic       res_use_hops;
        logic       load_out;
    } grt_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic idx_bad;
        logic idx_is_dest;
        logic clr_last;
        logic scan_none;
        logic scan_last;
        logic pipe_empty;
        logic have_hop;
        logic visited;
        logic pick_is_dest;
        logic out_busy;
    } grt_sts_t;

endpackage

@@ sv/grt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grt_ctrl
// sequencer for loads, visited clearing, per-hop scans and result handoff
// ----------------------------------------------------------------------------
module grt_ctrl import grt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     s_opcode,
    input  grt_sts_t sts,
    output grt_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CLEAR  = 9'b000000010,
        S_RDME   = 9'b000000100,
        S_LATCH  = 9'b000001000,
        S_SCAN   = 9'b000010000,
        S_DRAIN  = 9'b000100000,
        S_DECIDE = 9'b001000000,
        S_VCHK   = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_opcode == OP_LOAD) begin
                        cmd.load_wr = 1'b1;
                    end else if (sts.idx_bad) begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = ST_NO_HOP;
                        state_next     = S_FINISH;
                    end else if (sts.idx_is_dest) begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = ST_IS_DEST;
                        state_next     = S_FINISH;
                    end else begin
                        cmd.start_q = 1'b1;
                        state_next  = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) state_next = S_RDME;
            end
            S_RDME: begin
                cmd.rd_me  = 1'b1;
                state_next = S_LATCH;
            end
            S_LATCH: begin
                cmd.latch_me = 1'b1;
                state_next   = sts.scan_none ? S_DRAIN : S_SCAN;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) state_next = S_DRAIN;
            end
            S_DRAIN: begin
                if (sts.pipe_empty) state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (!sts.have_hop) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_NO_HOP;
                    state_next     = S_FINISH;
                end else begin
                    cmd.vis_rd = 1'b1;
                    state_next = S_VCHK;
                end
            end
            S_VCHK: begin
                if (sts.visited) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_LOOP;
                    state_next     = S_FINISH;
                end else if (sts.pick_is_dest) begin
                    cmd.vis_mark     = 1'b1;
                    cmd.set_res      = 1'b1;
                    cmd.res_status   = ST_REACHED;
                    cmd.res_use_hops = 1'b1;
                    state_next       = S_FINISH;
                end else begin
                    cmd.vis_mark = 1'b1;
                    cmd.adv_hop  = 1'b1;
                    state_next   = S_RDME;
                end
            end
            S_FINISH: begin
                if (!sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/grt_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grt_dp
// node table, visited map, distance pipeline, best tracking and output beat
// ----------------------------------------------------------------------------
module grt_dp import grt_pkg::*; #(
    parameter int MAX_NODES = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  grt_cmd_t             cmd,
    output grt_sts_t             sts,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [IDX_W-1:0]     in_index,
    input  logic [COORD_W-1:0]   in_tx,
    input  logic [COORD_W-1:0]   in_ty,
    input  logic [COORD_W-1:0]   in_px,
    input  logic [COORD_W-1:0]   in_py,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [1:0]           out_status,
    output logic [CNT_OUT_W-1:0] out_count
);

    localparam int IW    = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int SQ_W  = 2 * COORD_W;
    localparam int EW    = 4 * COORD_W;

    function automatic logic [COORD_W-1:0] abs_diff(logic [COORD_W-1:0] a,
                                                    logic [COORD_W-1:0] b);
        logic [COORD_W:0] d;
        logic [COORD_W:0] n;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        n = -d;
        return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
    endfunction

    // configuration
    logic [10:0]        node_count_reg;
    logic [IDX_W-1:0]   dest_id_reg;
    logic [CFG_W-1:0]   comm_range_reg;
    logic [SQ_W-1:0]    r2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= 11'd1024;
            dest_id_reg    <= '0;
            comm_range_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_NODE_COUNT: node_count_reg <= cfg_data[10:0];
                CFG_DEST_ID:    dest_id_reg    <= cfg_data[IDX_W-1:0];
                CFG_COMM_RANGE: comm_range_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        r2_reg <= comm_range_reg * comm_range_reg;
    end

    logic [CNT_W-1:0] n_eff;
    assign n_eff = (32'(node_count_reg) > 32'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                           : CNT_W'(node_count_reg);

    // walk state
    logic [IW-1:0]        cur_reg;
    logic [IW-1:0]        clr_cnt_reg;
    logic [CNT_W-1:0]     scan_cnt_reg;
    logic [CNT_OUT_W-1:0] hops_reg;

    // node table, entry {py, px, ty, tx}
    logic [EW-1:0] node_mem [MAX_NODES];
    logic [EW-1:0] rd_q;
    logic [IW-1:0] rd_addr;

    assign rd_addr = cmd.rd_me ? cur_reg : scan_cnt_reg[IW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load_wr && (32'(in_index) < 32'(MAX_NODES))) begin
            node_mem[IW'(in_index)] <= {in_py, in_px, in_ty, in_tx};
        end
        rd_q <= node_mem[rd_addr];
    end

    // visited map
    logic          vis_mem [MAX_NODES];
    logic          vis_q;
    logic [IW-1:0] pick_reg;

    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            vis_mem[clr_cnt_reg] <= (clr_cnt_reg == cur_reg);
        end else if (cmd.vis_mark) begin
            vis_mem[pick_reg] <= 1'b1;
        end
        if (cmd.vis_rd) vis_q <= vis_mem[pick_reg];
    end

    // current node entry
    logic [COORD_W-1:0] me_tx_reg, me_ty_reg, me_px_reg, me_py_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch_me) begin
            me_tx_reg <= rd_q[COORD_W-1:0];
            me_ty_reg <= rd_q[2*COORD_W-1:COORD_W];
            me_px_reg <= rd_q[3*COORD_W-1:2*COORD_W];
            me_py_reg <= rd_q[4*COORD_W-1:3*COORD_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg      <= '0;
            clr_cnt_reg  <= '0;
            scan_cnt_reg <= '0;
            hops_reg     <= '0;
        end else begin
            if (cmd.start_q) begin
                cur_reg     <= IW'(in_index);
                clr_cnt_reg <= '0;
                hops_reg    <= CNT_OUT_W'(2);
            end
            if (cmd.clr_step) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.latch_me) scan_cnt_reg <= '0;
            if (cmd.scan_step) scan_cnt_reg <= scan_cnt_reg + 1'b1;
            if (cmd.adv_hop) begin
                cur_reg <= pick_reg;
                if (hops_reg != '1) hops_reg <= hops_reg + 1'b1;
            end
        end
    end

    // distance pipeline: read, abs diff, square, sum and compare
    logic               v1_reg, v2_reg, v3_reg;
    logic [IW-1:0]      k1_reg, k2_reg, k3_reg;
    logic [COORD_W-1:0] dpx_reg, dpy_reg, dtx_reg, dty_reg;
    logic [SQ_W-1:0]    spx_reg, spy_reg, stx_reg, sty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.scan_step;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        k1_reg  <= scan_cnt_reg[IW-1:0];
        k2_reg  <= k1_reg;
        k3_reg  <= k2_reg;
        dpx_reg <= abs_diff(me_px_reg, rd_q[3*COORD_W-1:2*COORD_W]);
        dpy_reg <= abs_diff(me_py_reg, rd_q[4*COORD_W-1:3*COORD_W]);
        dtx_reg <= abs_diff(me_tx_reg, rd_q[3*COORD_W-1:2*COORD_W]);
        dty_reg <= abs_diff(me_ty_reg, rd_q[4*COORD_W-1:3*COORD_W]);
        spx_reg <= dpx_reg * dpx_reg;
        spy_reg <= dpy_reg * dpy_reg;
        stx_reg <= dtx_reg * dtx_reg;
        sty_reg <= dty_reg * dty_reg;
    end

    // own distance to the believed destination
    logic [COORD_W-1:0] otx_reg, oty_reg;
    logic [SQ_W-1:0]    sox_reg, soy_reg;

    always_ff @(posedge aclk) begin
        otx_reg <= abs_diff(me_tx_reg, me_px_reg);
        oty_reg <= abs_diff(me_ty_reg, me_py_reg);
        sox_reg <= otx_reg * otx_reg;
        soy_reg <= oty_reg * oty_reg;
    end

    logic [SQ_W:0] d_rng, d_tgt, d_own;
    logic          cand;
    logic          found_reg;
    logic [SQ_W:0] best_reg;

    assign d_rng = {1'b0, spx_reg} + {1'b0, spy_reg};
    assign d_tgt = {1'b0, stx_reg} + {1'b0, sty_reg};
    assign d_own = {1'b0, sox_reg} + {1'b0, soy_reg};
    assign cand  = v3_reg && (d_rng < {1'b0, r2_reg})
                   && !((k3_reg == cur_reg) && (32'(k3_reg) != 32'(dest_id_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.latch_me) begin
            found_reg <= 1'b0;
        end else if (cand && (!found_reg || (d_tgt < best_reg))) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cand && (!found_reg || (d_tgt < best_reg))) begin
            best_reg <= d_tgt;
            pick_reg <= k3_reg;
        end
    end

    // result and output beat
    logic [1:0]           res_status_reg;
    logic [CNT_OUT_W-1:0] res_count_reg;
    logic                 m_valid_reg;
    logic [1:0]           m_status_reg;
    logic [CNT_OUT_W-1:0] m_count_reg;

    always_ff @(posedge aclk) begin
        if (cmd.set_res) begin
            res_status_reg <= cmd.res_status;
            res_count_reg  <= cmd.res_use_hops ? hops_reg : '0;
        end
        if (cmd.load_out) begin
            m_status_reg <= res_status_reg;
            m_count_reg  <= res_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_count  = m_count_reg;

    assign sts.idx_bad      = (32'(in_index) >= 32'(MAX_NODES));
    assign sts.idx_is_dest  = (in_index == dest_id_reg);
    assign sts.clr_last     = (clr_cnt_reg == IW'(MAX_NODES - 1));
    assign sts.scan_none    = (n_eff == '0);
    assign sts.scan_last    = (scan_cnt_reg == n_eff - 1'b1);
    assign sts.pipe_empty   = !v1_reg && !v2_reg && !v3_reg;
    assign sts.have_hop     = found_reg && !(d_own < best_reg);
    assign sts.visited      = vis_q;
    assign sts.pick_is_dest = (32'(pick_reg) == 32'(dest_id_reg));
    assign sts.out_busy     = m_valid_reg && !m_tready;

endmodule

@@ sv/greedy_geo_route_tracer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_geo_route_tracer
// greedy geographic route tracing over a loadable node table
// ----------------------------------------------------------------------------
// usage:
//   s_ channel beats either load one node table entry (s_tuser opcode 0, no
//   result beat) or start a route trace from node_index (opcode 1, exactly
//   one result beat on the m_ channel).
//   the cfg_ channel writes node_count, dest_id and comm_range and is always
//   ready; it is to be written only while idle, not enforced by the block.
// trace sequence:
//   a trace first clears the visited map, then each hop fetches the current
//   node, scans the node table with one read per cycle through a four-stage
//   distance pipeline and checks the visited map for the picked node. a bad
//   or destination start index is answered without clearing or scanning.
// reset:
//   aresetn (sync, active low) returns to idle, drops m_tvalid and restores
//   node_count 1024, dest_id 0, comm_range 0; node table content is kept.
// stall:
//   a result waits in the output register; s_tready drops while a trace
//   runs or its result cannot yet be placed.
// ----------------------------------------------------------------------------
module greedy_geo_route_tracer import grt_pkg::*; #(
    parameter int MAX_NODES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // node_index[9:0], target_x[25:10], target_y[41:26],
                                   // pos_x[57:42], pos_y[73:58], zero pad
    input  logic [0:0]  s_tuser,   // opcode[0]
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status[1:0], hop_total[12:2], zero pad
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    grt_cmd_t             cmd;
    grt_sts_t             sts;
    logic [1:0]           out_status;
    logic [CNT_OUT_W-1:0] out_count;

    // config always accepted
    assign cfg_ready = 1'b1;

    grt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_opcode (s_tuser[0]),
        .sts      (sts),
        .cmd      (cmd)
    );

    grt_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_index   (s_tdata[9:0]),
        .in_tx      (s_tdata[25:10]),
        .in_ty      (s_tdata[41:26]),
        .in_px      (s_tdata[57:42]),
        .in_py      (s_tdata[73:58]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_status (out_status),
        .out_count  (out_count)
    );

    assign m_tdata = {3'b000, out_count, out_status};

endmodule
